// File: rtl/ghs_pkg.sv
// Shared types and constants for the 3x3 grayscale sharpening filter.
// No dependencies; imported by ghs_kernel and gray_highpass_sharpen_3x3.
`timescale 1ns / 1ps

package ghs_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned WidthW    = 11;
  localparam int unsigned HeightW   = 13;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [WidthW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightW-1:0] HeightReset = 13'd480;

  // Register indexes of the configuration port.
  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_index_e;

  // The nine pixels of one 3x3 window: left, centre and right columns.
  typedef struct packed {
    logic [PixW-1:0] l_top;
    logic [PixW-1:0] l_mid;
    logic [PixW-1:0] l_bot;
    logic [PixW-1:0] c_top;
    logic [PixW-1:0] c_mid;
    logic [PixW-1:0] c_bot;
    logic [PixW-1:0] r_top;
    logic [PixW-1:0] r_mid;
    logic [PixW-1:0] r_bot;
  } taps_t;

endpackage

// File: rtl/ghs_kernel.sv
// High-pass kernel and sharpening arithmetic for one 3x3 window.
// Depends on ghs_pkg for the window type and pixel width.
`timescale 1ns / 1ps

module ghs_kernel import ghs_pkg::*; (
  input  taps_t           taps_i,
  output logic [PixW-1:0] pixel_o
);

  // centre + 3/8 * (12*c - corners - 2*sides), scaled by eight:
  // 44*c - 3*corners - 6*sides.
  localparam logic signed [15:0] CentreGain = 16'sd44;
  localparam logic signed [15:0] CornerGain = 16'sd3;
  localparam logic signed [15:0] SideGain   = 16'sd6;

  logic [9:0]         corners;
  logic [9:0]         sides;
  logic signed [15:0] centre_s;
  logic signed [15:0] corner_s;
  logic signed [15:0] side_s;
  logic signed [15:0] acc;
  logic [11:0]        scaled;

  always_comb begin
    corners  = 10'({2'b0, taps_i.l_top}) + 10'({2'b0, taps_i.l_bot})
             + 10'({2'b0, taps_i.r_top}) + 10'({2'b0, taps_i.r_bot});
    sides    = 10'({2'b0, taps_i.l_mid}) + 10'({2'b0, taps_i.c_top})
             + 10'({2'b0, taps_i.c_bot}) + 10'({2'b0, taps_i.r_mid});
    centre_s = $signed({8'd0, taps_i.c_mid});
    corner_s = $signed({6'd0, corners});
    side_s   = $signed({6'd0, sides});
    acc      = CentreGain * centre_s - CornerGain * corner_s - SideGain * side_s;
    scaled   = acc[14:3];
    if (acc[15]) begin
      pixel_o = '0;
    end else if (scaled > 12'd255) begin
      pixel_o = '1;
    end else begin
      pixel_o = scaled[PixW-1:0];
    end
  end

endmodule

// File: rtl/gray_highpass_sharpen_3x3.sv
// Top level of the 3x3 high-pass sharpening filter for 8-bit grayscale frames.
// Depends on ghs_pkg and instantiates ghs_kernel.
`timescale 1ns / 1ps

// Pixels enter one item per clock in raster order and the block sustains one
// item per cycle; an item is taken whenever the single working stage is empty
// or moving on, so stalls only come from a full output register. A result
// is registered as the pixel below and to the right of its centre leaves the
// working stage; only interior pixels give a result, so the first two rows and
// the first two columns of each row produce nothing. The two previous rows
// live in one line store of 1024 entries, each holding the pixel two rows up
// and the pixel one row up; the store is read when an item is accepted and
// written back with the shifted pair as the working stage moves on. Because
// consecutive items always sit in different columns, the read of one item
// never meets the pending write of the one before. The line store is not
// cleared after reset; its unwritten entries only feed windows of the first
// two rows, which give no result. Writing either size register restarts the
// frame at row zero, column zero and must only happen while the block is idle.

module gray_highpass_sharpen_3x3 import ghs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Pixel input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     pixel_in_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixW-1:0]     sharpened_o,
  output logic [ColW-1:0]     out_col_o,
  output logic [RowW-1:0]     out_row_o,
  output logic                frame_last_o
);

  // Configuration and position counters.
  logic [WidthW-1:0]  width_q, width_d;
  logic [HeightW-1:0] height_q, height_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [ColW-1:0]    last_col;
  logic [RowW-1:0]    last_row;

  // Working stage: the accepted pixel waits here for the line store data.
  logic               s1_valid_q, s1_valid_d;
  logic [PixW-1:0]    s1_pix_q;
  logic [ColW-1:0]    s1_col_q;
  logic [RowW-1:0]    s1_row_q;
  logic               s1_prod_q;
  logic               s1_last_q;
  logic               s1_adv;
  logic               in_accept;

  // Line store: each entry holds {pixel two rows up, pixel one row up}.
  logic [2*PixW-1:0]  line_mem [MaxWidth];
  logic [2*PixW-1:0]  rd_q;

  // Left and centre columns of the window.
  logic [PixW-1:0]    win_q [6];

  taps_t              taps;
  logic [PixW-1:0]    kernel_pix;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [PixW-1:0]    sharp_q;
  logic [ColW-1:0]    ocol_q;
  logic [RowW-1:0]    orow_q;
  logic               olast_q;

  // Effective frame size: out-of-range values are pulled into range.
  always_comb begin
    if (width_q < WidthW'(3)) begin
      last_col = ColW'(2);
    end else if (width_q > WidthW'(MaxWidth)) begin
      last_col = ColW'(MaxWidth - 1);
    end else begin
      last_col = ColW'(width_q - WidthW'(1));
    end
    if (height_q < HeightW'(3)) begin
      last_row = RowW'(2);
    end else if (height_q > HeightW'(MaxHeight)) begin
      last_row = RowW'(MaxHeight - 1);
    end else begin
      last_row = RowW'(height_q - HeightW'(1));
    end
  end

  // The working stage moves on unless it carries a result and the output
  // register is still full.
  assign s1_adv     = s1_valid_q && (!s1_prod_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  // Configuration has priority; a write restarts the frame.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_WIDTH: begin
          width_d = cfg_data_i[WidthW-1:0];
        end
        CFG_HEIGHT: begin
          height_d = cfg_data_i[HeightW-1:0];
        end
        default: begin
          width_d = width_q;
        end
      endcase
      col_d = '0;
      row_d = '0;
    end else if (in_accept) begin
      if (col_q == last_col) begin
        col_d = '0;
        row_d = (row_q == last_row) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q  <= pixel_in_i;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_prod_q <= (row_q >= RowW'(2)) && (col_q >= ColW'(2));
      s1_last_q <= (row_q == last_row) && (col_q == last_col);
    end
  end

  // Read on acceptance, write back the shifted column pair when the
  // working stage moves on. The read data stays put while the stage stalls.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_adv) begin
      line_mem[s1_col_q] <= {rd_q[PixW-1:0], s1_pix_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= rd_q[2*PixW-1:PixW];
      win_q[4] <= rd_q[PixW-1:0];
      win_q[5] <= s1_pix_q;
    end
  end

  always_comb begin
    taps.l_top = win_q[0];
    taps.l_mid = win_q[1];
    taps.l_bot = win_q[2];
    taps.c_top = win_q[3];
    taps.c_mid = win_q[4];
    taps.c_bot = win_q[5];
    taps.r_top = rd_q[2*PixW-1:PixW];
    taps.r_mid = rd_q[PixW-1:0];
    taps.r_bot = s1_pix_q;
  end

  ghs_kernel u_kernel (
    .taps_i  (taps),
    .pixel_o (kernel_pix)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_prod_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_prod_q) begin
      sharp_q <= kernel_pix;
      ocol_q  <= s1_col_q - ColW'(1);
      orow_q  <= s1_row_q - RowW'(1);
      olast_q <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sharpened_o  = sharp_q;
  assign out_col_o    = ocol_q;
  assign out_row_o    = orow_q;
  assign frame_last_o = olast_q;

  // The read of a new item never targets the entry still to be written back.
  a_no_store_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s1_adv) |-> (col_q != s1_col_q))
    else $error("line store read and write-back hit the same entry");

  // Position counters never pass the effective frame edges.
  a_col_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= last_col)
    else $error("column counter beyond frame width");

  a_row_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= last_row)
    else $error("row counter beyond frame height");

  // Only interior pixels are ever reported.
  a_interior_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_col_o != '0) && (out_row_o != '0))
    else $error("result reported for a border pixel");

endmodule

// File: test/ghs_sharpen_checker.sv
// Checker for the 3x3 grayscale sharpening filter. It watches the pixel,
// result and size-register ports, predicts every filtered pixel and compares.
// Depends on ghs_pkg for widths, reset sizes and register indexes.
`timescale 1ns / 1ps

module ghs_sharpen_checker import ghs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [PixW-1:0]     pixel_in_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [PixW-1:0]     sharpened_i,
  input  logic [ColW-1:0]     out_col_i,
  input  logic [RowW-1:0]     out_row_i,
  input  logic                frame_last_i,
  output int                  awaited_o,
  output int                  checked_o,
  output int                  mismatches_o
);

  localparam int ReportCap = 100;

  typedef struct packed {
    logic [PixW-1:0] sharpened;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            frame_last;
  } filtered_pixel_t;

  filtered_pixel_t awaited_pixels[$];

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [PixW-1:0]    line_two_up[MaxWidth];
  logic [PixW-1:0]    line_one_up[MaxWidth];
  // Window columns, each held as top, middle, bottom.
  logic [PixW-1:0]    left_col[3];
  logic [PixW-1:0]    centre_col[3];
  int unsigned        col_pos;
  int unsigned        row_pos;

  task automatic clear_model();
    width_q  = WidthReset;
    height_q = HeightReset;
    for (int i = 0; i < MaxWidth; i++) begin
      line_two_up[i] = '0;
      line_one_up[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      left_col[i]   = '0;
      centre_col[i] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    awaited_pixels.delete();
  endtask

  task automatic predict_sharpened(input logic [PixW-1:0] pix);
    int unsigned     w, h, c, r;
    int              top, mid, bot, l_top, l_mid, l_bot, c_top, c_mid, c_bot;
    int              acc, t;
    filtered_pixel_t res;
    w = (width_q < 3) ? 3 : (width_q > MaxWidth) ? MaxWidth : width_q;
    h = (height_q < 3) ? 3 : (height_q > MaxHeight) ? MaxHeight : height_q;
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    bot   = pix;
    top   = line_two_up[c];
    mid   = line_one_up[c];
    l_top = left_col[0];
    l_mid = left_col[1];
    l_bot = left_col[2];
    c_top = centre_col[0];
    c_mid = centre_col[1];
    c_bot = centre_col[2];
    if (r >= 2 && c >= 2) begin
      acc = 12 * c_mid - l_top - l_bot - top - bot
            - 2 * (c_top + l_mid + mid + c_bot);
      t = 8 * c_mid + 3 * acc;
      if (t < 0) begin
        t = 0;
      end else begin
        t = t / 8;
        if (t > 255) t = 255;
      end
      res.sharpened  = PixW'(t);
      res.col        = ColW'(c - 1);
      res.row        = RowW'(r - 1);
      res.frame_last = (r == h - 1) && (c == w - 1);
      awaited_pixels.push_back(res);
    end
    for (int i = 0; i < 3; i++) left_col[i] = centre_col[i];
    centre_col[0] = PixW'(top);
    centre_col[1] = PixW'(mid);
    centre_col[2] = PixW'(bot);
    line_two_up[c] = PixW'(mid);
    line_one_up[c] = PixW'(bot);
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    mismatches_o++;
    if (mismatches_o <= ReportCap) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end else if (mismatches_o == ReportCap + 1) begin
      $display("%0t ns: further mismatches are counted but not shown", $time);
    end
  endtask

  task automatic compare_result();
    filtered_pixel_t want;
    if (awaited_pixels.size() == 0) begin
      report_field("unexpected result (sharpened)", 32'hFFFF_FFFF, sharpened_i);
    end else begin
      want = awaited_pixels.pop_front();
      checked_o++;
      if (sharpened_i !== want.sharpened)
        report_field("sharpened", want.sharpened, sharpened_i);
      if (out_col_i !== want.col)
        report_field("out_col", want.col, out_col_i);
      if (out_row_i !== want.row)
        report_field("out_row", want.row, out_row_i);
      if (frame_last_i !== want.frame_last)
        report_field("frame_last", want.frame_last, frame_last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_WIDTH) width_q = cfg_data_i[WidthW-1:0];
        else height_q = cfg_data_i[HeightW-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      if (in_valid_i && in_ready_i) predict_sharpened(pixel_in_i);
      if (out_valid_i && out_ready_i) compare_result();
    end
    awaited_o = awaited_pixels.size();
  end

endmodule

// File: test/gray_highpass_sharpen_3x3_tb.sv
// Testbench top for the 3x3 grayscale sharpening filter: drives size
// registers and pixel frames, stalls the result side and gives the verdict.
// Depends on ghs_pkg, gray_highpass_sharpen_3x3 and ghs_sharpen_checker.
`timescale 1ns / 1ps

module gray_highpass_sharpen_3x3_tb;
  import ghs_pkg::*;

  localparam int HalfPeriod  = 10;
  localparam int ResetCycles = 9;
  localparam int RandomItems = 1400;
  // Spare cycles waited after the last result has been taken, before the block
  // is taken to be idle.
  localparam int DrainCycles = 8;
  // Roughly 1,900 items in all, and under 4,500 even if the last random phase
  // runs long. Even if every item met the longest sender gap and the longest
  // receiver stall, the run would still end before the limit is reached.
  localparam int CycleLimit  = 2_000_000;

  // How the pixels of one phase are drawn.
  typedef enum logic [1:0] {
    PIX_EXTREME,
    PIX_FLAT,
    PIX_ANY
  } pix_style_e;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic                cfg_index  = CFG_WIDTH;
  logic [CfgDataW-1:0] cfg_data   = '0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [PixW-1:0]     pixel_in   = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [PixW-1:0]     sharpened;
  logic [ColW-1:0]     out_col;
  logic [RowW-1:0]     out_row;
  logic                frame_last;

  int          awaited;
  int          checked;
  int          mismatches;
  int          cycles         = 0;
  int unsigned items_sent     = 0;
  int unsigned phases         = 0;
  // Percentages of items that are preceded by an idle gap, and of cycles
  // that start a stall on the result side. Both are reset for every phase.
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  always #HalfPeriod clk = ~clk;

  gray_highpass_sharpen_3x3 i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .pixel_in_i   (pixel_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .sharpened_o  (sharpened),
    .out_col_o    (out_col),
    .out_row_o    (out_row),
    .frame_last_o (frame_last)
  );

  ghs_sharpen_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .pixel_in_i   (pixel_in),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .sharpened_i  (sharpened),
    .out_col_i    (out_col),
    .out_row_i    (out_row),
    .frame_last_i (frame_last),
    .awaited_o    (awaited),
    .checked_o    (checked),
    .mismatches_o (mismatches)
  );

  // One gap or stall in ten is a long one; the rest are short.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  // The result side: ready is high unless a stall is running. Stalls begin
  // at random, so they land on every phase of the block's pipeline.
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < recv_stall_pct) hold = pick_gap();
      end
    end
  end

  // Every task below starts and ends on a falling edge, so each input gets
  // at most one assignment per edge and changes well away from sampling.
  task automatic send_pixel(input logic [PixW-1:0] pix);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < send_gap_pct) ? pick_gap() : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic stream_pixels(input int unsigned count, input pix_style_e style);
    logic [PixW-1:0] base;
    logic [PixW-1:0] pix;
    base = PixW'($urandom_range(20, 235));
    for (int unsigned n = 0; n < count; n++) begin
      case (style)
        PIX_EXTREME: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        // Gentle texture around a level keeps many results off the clamps.
        PIX_FLAT:    pix = base + PixW'($urandom_range(0, 16)) - 8'd8;
        default:     pix = PixW'($urandom_range(0, 255));
      endcase
      send_pixel(pix);
    end
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Size writes restart the frame, so they wait until every filtered pixel
  // has come out and the last border pixels have left the pipeline.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Run-away guard: a hung handshake or a missing result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned random_items;
    int unsigned sel, w_val, h_val, eff_w, eff_h, frame_px, count;
    random_items = 0;

    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Sizes of zero clamp to the smallest 3x3 frame, which has
    // a single interior pixel. Three back-to-back frames also exercise the
    // wrap to a new frame: a bright centre on black clamps high, a black
    // centre on white clamps low, and a faint bump on grey lands in range.
    write_reg(CFG_WIDTH, '0);
    write_reg(CFG_HEIGHT, '0);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd255 : 8'd0);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd0 : 8'd255);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd129 : 8'd128);
    wait_idle();
    phases++;
    eff_w = 3;
    eff_h = 3;

    // Random part: small frames of assorted sizes, mostly whole frames with
    // random content, some cut short by the next size write. Now and then both
    // registers are left alone, so the frame carries on from where it stood.
    // Width writes carry junk in the data bits above the width field.
    while (random_items < RandomItems) begin
      sel   = $urandom_range(0, 9);
      w_val = (sel == 0) ? $urandom_range(0, 2) :
              (sel < 8)  ? $urandom_range(3, 12) : $urandom_range(13, 64);
      sel   = $urandom_range(0, 9);
      h_val = (sel == 0) ? $urandom_range(0, 2) :
              (sel < 8)  ? $urandom_range(3, 8) : $urandom_range(9, 20);
      if ($urandom_range(0, 3) != 0) begin
        write_reg(CFG_WIDTH, CfgDataW'({$urandom_range(0, 3), WidthW'(w_val)}));
        eff_w = (w_val < 3) ? 3 : w_val;
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(CFG_HEIGHT, CfgDataW'(h_val));
        eff_h = (h_val < 3) ? 3 : h_val;
      end
      frame_px = eff_w * eff_h;
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, frame_px)
                                          : frame_px * $urandom_range(1, 2);
      send_gap_pct   = pick_pct();
      recv_stall_pct = pick_pct();
      stream_pixels(count, pix_style_e'($urandom_range(0, 2)));
      random_items += count;
      phases++;
      wait_idle();
    end

    // Over-range sizes that clamp: a short run at a width of 2047, taken as
    // the widest row, which stays inside the first row and so gives nothing,
    // then a narrow frame with a height of 8191, cut short after 100 rows.
    // Idling is kept light.
    send_gap_pct   = 5;
    recv_stall_pct = 5;
    write_reg(CFG_WIDTH, CfgDataW'(2047));
    write_reg(CFG_HEIGHT, CfgDataW'(3));
    stream_pixels(100, PIX_ANY);
    wait_idle();
    write_reg(CFG_WIDTH, CfgDataW'(3));
    write_reg(CFG_HEIGHT, CfgDataW'(8191));
    stream_pixels(300, PIX_ANY);
    wait_idle();
    phases += 2;

    $display("Streamed %0d pixels over %0d size settings; %0d filtered pixels compared.",
             items_sent, phases, checked);
    $display("Sizes ran from clamped minimum frames through small random frames to clamped over-range widths and heights.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ghs_pkg.sv
rtl/ghs_kernel.sv
rtl/gray_highpass_sharpen_3x3.sv
test/ghs_sharpen_checker.sv
test/gray_highpass_sharpen_3x3_tb.sv
